// File: rtl/cdta_pkg.sv
// Package for the calendar date/time advance block.
// Holds payload structs, calendar constants and controller/datapath
// command and status types. No dependencies.
package cdta_pkg;

  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned HourPerDay  = 24;
  localparam int unsigned MonPerYear  = 12;
  localparam int unsigned YearsPerCen = 100;
  localparam logic [15:0] ResetYear   = 16'd2023;
  // 2023 = 20 * 100 + 23; century count 20 is 0 modulo 4
  localparam logic [6:0]  ResetYrMod  = 7'd23;
  localparam logic [1:0]  ResetCenMod = 2'd0;

  typedef struct packed {
    logic [7:0] add_days;
    logic [7:0] add_hours;
    logic [7:0] add_minutes;
  } in_t;

  typedef struct packed {
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic do_min;    // fold minutes, record carry
    logic do_hour;   // fold hours, form day sum
    logic step;      // cross one month
    logic commit;    // write day, load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic roll_done; // day sum fits the current month
  } sts_t;

endpackage

// File: rtl/calendar_date_time_advance.sv
// Top level of the calendar date/time advance block.
// Joins the controller (cdta_ctrl) and datapath (cdta_dp); types from cdta_pkg.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    cdta_pkg::in_t  (days, hours, minutes)
//   out_     output     out_valid / out_ready  cdta_pkg::out_t (minute .. year)
//
// Sequence: after a transaction is accepted, the controller folds minutes,
//   then hours, then crosses one month per step in the rollover loop
//   (0..9 months), then commits the result to the output register. A new
//   transaction is accepted only after the commit.
// Reset: synchronous, active low; date/time returns to 00:00, Jan 1, 2023.
// Stalls: the result sits in an output register; a new transaction is taken
//   while it waits. If the next result is ready before the old one is taken,
//   the controller holds in the rollover state until the register frees.
module calendar_date_time_advance (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdta_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cdta_pkg::out_t  out_data
);
  import cdta_pkg::*;

  cmd_t cmd;   // step commands
  sts_t sts;   // rollover status

  cdta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdta_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: rtl/cdta_ctrl.sv
// Controller FSM for the calendar date/time advance block.
// Sequences minute, hour and month-rollover steps; owns out_valid.
// Depends on cdta_pkg.
module cdta_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cdta_pkg::sts_t  sts,
  output cdta_pkg::cmd_t  cmd
);
  import cdta_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIN,
    S_HOUR,
    S_ROLL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.do_min  = (state_r == S_MIN);
    cmd.do_hour = (state_r == S_HOUR);
    cmd.step    = (state_r == S_ROLL) && !sts.roll_done;
    cmd.commit  = (state_r == S_ROLL) && sts.roll_done && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MIN;
      end
      S_MIN:  state_nxt = S_HOUR;
      S_HOUR: state_nxt = S_ROLL;
      S_ROLL: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/cdta_dp.sv
// Datapath for the calendar date/time advance block.
// Calendar state, carry folding, month rollover and output register.
// Depends on cdta_pkg.
module cdta_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  cdta_pkg::in_t   in_data,
  input  cdta_pkg::cmd_t  cmd,
  output cdta_pkg::sts_t  sts,
  output cdta_pkg::out_t  out_data
);
  import cdta_pkg::*;

  localparam int unsigned MaxMinCarry  = 5;   // (59 + 255) / 60
  localparam int unsigned MaxHourCarry = 11;  // (23 + 255 + 5) / 24

  // architectural state
  logic [5:0]  minute_r;
  logic [4:0]  hour_r;
  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [15:0] year_r;
  logic [6:0]  yr_mod_r;   // year mod 100
  logic [1:0]  cen_mod_r;  // (year / 100) mod 4

  // per-transaction working registers
  in_t         add_r;
  logic [2:0]  cm_r;       // minute carry into hours
  logic [8:0]  dsum_r;     // remaining day count
  out_t        out_r;

  // minute fold
  logic [8:0]  msum;
  logic [2:0]  mq;
  logic [8:0]  mrem;
  // hour fold
  logic [8:0]  hsum;
  logic [3:0]  hq;
  logic [8:0]  hrem;
  // month rollover
  logic        leap;
  logic [4:0]  mlen;
  logic [3:0]  mon_inc;
  logic        yr_wrap;

  always_comb begin
    msum = 9'(minute_r) + 9'(add_r.add_minutes);
    mq   = '0;
    mrem = msum;
    for (int k = 1; k <= MaxMinCarry; k++) begin
      if (msum >= 9'(k * MinPerHour)) begin
        mq   = 3'(k);
        mrem = msum - 9'(k * MinPerHour);
      end
    end
  end

  always_comb begin
    hsum = 9'(hour_r) + 9'(add_r.add_hours) + 9'(cm_r);
    hq   = '0;
    hrem = hsum;
    for (int k = 1; k <= MaxHourCarry; k++) begin
      if (hsum >= 9'(k * HourPerDay)) begin
        hq   = 4'(k);
        hrem = hsum - 9'(k * HourPerDay);
      end
    end
  end

  // divisible by 4, and not by 100 unless by 400
  assign leap = (year_r[1:0] == 2'd0) && ((yr_mod_r != 7'd0) || (cen_mod_r == 2'd0));

  always_comb begin
    case (month_r)
      4'd2:    mlen = leap ? 5'd29 : 5'd28;
      4'd4:    mlen = 5'd30;
      4'd6:    mlen = 5'd30;
      4'd9:    mlen = 5'd30;
      4'd11:   mlen = 5'd30;
      default: mlen = 5'd31;  // 31-day months and unused codes
    endcase
  end

  assign mon_inc       = month_r + 4'd1;
  assign yr_wrap       = (mon_inc > 4'(MonPerYear)) || (mon_inc == 4'd0);
  assign sts.roll_done = (dsum_r <= 9'(mlen));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minute_r  <= '0;
      hour_r    <= '0;
      day_r     <= 5'd1;
      month_r   <= 4'd1;
      year_r    <= ResetYear;
      yr_mod_r  <= ResetYrMod;
      cen_mod_r <= ResetCenMod;
    end else begin
      if (cmd.do_min)  minute_r <= mrem[5:0];
      if (cmd.do_hour) hour_r   <= hrem[4:0];
      if (cmd.commit)  day_r    <= dsum_r[4:0];
      if (cmd.step) begin
        if (yr_wrap) begin
          month_r <= 4'd1;
          year_r  <= year_r + 16'd1;
          if (year_r == 16'hFFFF) begin
            // year 0: divisible by 400
            yr_mod_r  <= '0;
            cen_mod_r <= '0;
          end else if (yr_mod_r == 7'(YearsPerCen - 1)) begin
            yr_mod_r  <= '0;
            cen_mod_r <= cen_mod_r + 2'd1;
          end else begin
            yr_mod_r  <= yr_mod_r + 7'd1;
          end
        end else begin
          month_r <= mon_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)    add_r  <= in_data;
    if (cmd.do_min)  cm_r   <= mq;
    if (cmd.do_hour) dsum_r <= 9'(day_r) + 9'(add_r.add_days) + 9'(hq);
    if (cmd.step)    dsum_r <= dsum_r - 9'(mlen);
    if (cmd.commit) begin
      out_r.cur_minute <= minute_r;
      out_r.cur_hour   <= hour_r;
      out_r.cur_day    <= dsum_r[4:0];
      out_r.cur_month  <= month_r;
      out_r.cur_year   <= year_r;
    end
  end

  assign out_data = out_r;

endmodule
